@@ rtl/i2cm_pkg.sv @@
// Shared types, constants and bus-level decode for the I2C master byte engine.
`default_nettype none
package i2cm_pkg;

  // Default width of the phase hold counter
  localparam int DELAY_WIDTH_DEF = 16;

  // Width of the phase_ticks register
  localparam int PHASE_TICKS_W = 16;

  // Reset values of the configuration registers
  localparam logic [PHASE_TICKS_W-1:0] PHASE_TICKS_RST = 16'd10;
  localparam logic                     ACK_CHECK_RST   = 1'b1;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_PHASE_TICKS = 1'b0,
    CFG_ACK_CHECK   = 1'b1
  } cfg_idx_t;

  // Bus sequencer phases, one-hot
  typedef enum logic [12:0] {
    PH_IDLE  = 13'b0000000000001,
    PH_ST_A  = 13'b0000000000010,
    PH_ST_B  = 13'b0000000000100,
    PH_W_LO  = 13'b0000000001000,
    PH_W_HI  = 13'b0000000010000,
    PH_WA_LO = 13'b0000000100000,
    PH_WA_HI = 13'b0000001000000,
    PH_R_LO  = 13'b0000010000000,
    PH_R_HI  = 13'b0000100000000,
    PH_RA_LO = 13'b0001000000000,
    PH_RA_HI = 13'b0010000000000,
    PH_SP_A  = 13'b0100000000000,
    PH_SP_B  = 13'b1000000000000
  } phase_t;

  // Latched command options
  typedef struct packed {
    logic rd;
    logic stop;
    logic ack;
  } cmd_flags_t;

  // SCL level and SDA release for one phase
  typedef struct packed {
    logic scl;
    logic sda;
  } bus_lvl_t;

  // Bus levels shown while a phase is held
  function automatic bus_lvl_t phase_levels(phase_t ph, logic data_bit, logic give_ack);
    bus_lvl_t lv;
    lv.scl = 1'b1;
    lv.sda = 1'b1;
    case (ph)
      PH_ST_A:  begin lv.scl = 1'b1; lv.sda = 1'b1;      end
      PH_ST_B:  begin lv.scl = 1'b1; lv.sda = 1'b0;      end
      PH_W_LO:  begin lv.scl = 1'b0; lv.sda = data_bit;  end
      PH_W_HI:  begin lv.scl = 1'b1; lv.sda = data_bit;  end
      PH_WA_LO: begin lv.scl = 1'b0; lv.sda = 1'b1;      end
      PH_WA_HI: begin lv.scl = 1'b1; lv.sda = 1'b1;      end
      PH_R_LO:  begin lv.scl = 1'b0; lv.sda = 1'b1;      end
      PH_R_HI:  begin lv.scl = 1'b1; lv.sda = 1'b1;      end
      PH_RA_LO: begin lv.scl = 1'b0; lv.sda = ~give_ack; end
      PH_RA_HI: begin lv.scl = 1'b1; lv.sda = ~give_ack; end
      PH_SP_A:  begin lv.scl = 1'b0; lv.sda = 1'b0;      end
      PH_SP_B:  begin lv.scl = 1'b1; lv.sda = 1'b0;      end
      default:  begin lv.scl = 1'b1; lv.sda = 1'b1;      end
    endcase
    return lv;
  endfunction

endpackage
`default_nettype wire

@@ rtl/i2c_master_byte_engine.sv @@
// Top level of the I2C master byte engine: tick sequencer and result register.
//
// Usage: every word on the input channel is one bus tick. It carries an
// optional byte command (in_cmd_valid with op, START/STOP options, the write
// byte and the read ACK choice) and the sampled SDA level. Each accepted word
// produces exactly one result word on the output channel: SCL level, SDA
// release, busy, a one-tick done pulse, the last read byte and the NACK flag.
// Commands offered while a command is in progress are ignored.
// The result of a tick is registered as the tick is accepted and presented
// from a single output register. Throughput: one tick per cycle;
// the sequencer state and the output register are updated in the same edge,
// and in_ready stays high while the output register is empty or being taken.
// When the receiver stalls, the result holds and in_ready drops, so ticks
// pause without loss. Each bus phase lasts phase_ticks accepted ticks, clamped
// to 1 .. the hold counter maximum; a byte with START and STOP spans 22 phases.
// Configuration writes (cfg_we) take effect at once; cfg_addr 0 is
// phase_ticks, 1 is ack_check. Reset (synchronous, rst_n low) returns the
// sequencer to idle with the bus released high, clears status and read data,
// empties the output register and restores phase_ticks 10 and ack_check 1.
`default_nettype none
module i2c_master_byte_engine #(
  parameter int DELAY_WIDTH = i2cm_pkg::DELAY_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Configuration
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_addr,
  input  wire logic [i2cm_pkg::PHASE_TICKS_W-1:0] cfg_wdata,
  // Tick input
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire logic                               in_cmd_valid,
  input  wire logic                               in_op,
  input  wire logic                               in_with_start,
  input  wire logic                               in_with_stop,
  input  wire logic [7:0]                         in_write_byte,
  input  wire logic                               in_give_ack,
  input  wire logic                               in_sda_in,
  // Result output
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      logic                               out_scl_out,
  output      logic                               out_sda_release,
  output      logic                               out_busy_res,
  output      logic                               out_done_res,
  output      logic [7:0]                         out_read_byte,
  output      logic                               out_got_nack
);
  import i2cm_pkg::*;

  localparam int LIM_W = (DELAY_WIDTH > PHASE_TICKS_W) ? DELAY_WIDTH : PHASE_TICKS_W;

  // Configuration registers
  logic [PHASE_TICKS_W-1:0] phase_ticks_r;
  logic                     ack_check_r;

  // Sequencer state
  phase_t                 phase_r, phase_nxt;
  logic [3:0]             bit_idx_r, bit_idx_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [DELAY_WIDTH-1:0] tick_r, tick_nxt;
  cmd_flags_t             flags_r, flags_nxt;
  logic                   scl_r, scl_nxt;
  logic                   sda_r, sda_nxt;
  logic                   nack_r, nack_nxt;
  logic [7:0]             rdata_r, rdata_nxt;

  // Output register
  logic                   out_valid_r;
  logic                   done_r, done_nxt;
  logic                   busy_r;

  // Step helpers
  logic                   accept;
  logic [DELAY_WIDTH-1:0] tick_inc;
  logic [LIM_W-1:0]       cap_w, pt_w, lim_w;
  logic                   phase_end;
  logic                   go_enter;
  logic                   go_finish;
  phase_t                 ph_new;
  bus_lvl_t               fin_lvl;
  bus_lvl_t               new_lvl;

  assign accept   = in_valid & in_ready;
  assign in_ready = ~out_valid_r | out_ready;

  // Clamp the hold limit to 1 .. counter maximum
  assign cap_w = LIM_W'({DELAY_WIDTH{1'b1}});
  assign pt_w  = LIM_W'(phase_ticks_r);
  always_comb begin
    if (pt_w == '0) begin
      lim_w = LIM_W'(1);
    end else if (pt_w > cap_w) begin
      lim_w = cap_w;
    end else begin
      lim_w = pt_w;
    end
  end

  assign tick_inc  = tick_r + DELAY_WIDTH'(1);
  assign phase_end = (LIM_W'(tick_inc) >= lim_w);

  // Compute one tick of the sequencer
  always_comb begin
    phase_nxt   = phase_r;
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    tick_nxt    = tick_r;
    flags_nxt   = flags_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    nack_nxt    = nack_r;
    rdata_nxt   = rdata_r;
    done_nxt    = 1'b0;
    go_enter    = 1'b0;
    go_finish   = 1'b0;
    ph_new      = PH_IDLE;
    fin_lvl     = '{scl: 1'b1, sda: 1'b1};

    if (phase_r == PH_IDLE) begin
      // Latch a new command
      if (in_cmd_valid) begin
        flags_nxt.rd   = in_op;
        flags_nxt.stop = in_with_stop;
        flags_nxt.ack  = in_give_ack;
        shift_nxt      = in_op ? 8'h00 : in_write_byte;
        bit_idx_nxt    = 4'd0;
        go_enter       = 1'b1;
        if (in_with_start) begin
          ph_new = PH_ST_A;
        end else begin
          ph_new = in_op ? PH_R_LO : PH_W_LO;
        end
      end
    end else begin
      tick_nxt = tick_inc;
      if (phase_end) begin
        // Advance to the next phase
        case (phase_r)
          PH_ST_A: begin
            go_enter = 1'b1;
            ph_new   = PH_ST_B;
          end
          PH_ST_B: begin
            go_enter    = 1'b1;
            bit_idx_nxt = 4'd0;
            ph_new      = flags_r.rd ? PH_R_LO : PH_W_LO;
          end
          PH_W_LO: begin
            go_enter = 1'b1;
            ph_new   = PH_W_HI;
          end
          PH_W_HI: begin
            go_enter    = 1'b1;
            shift_nxt   = {shift_r[6:0], 1'b0};
            bit_idx_nxt = bit_idx_r + 4'd1;
            ph_new      = (bit_idx_nxt >= 4'd8) ? PH_WA_LO : PH_W_LO;
          end
          PH_WA_LO: begin
            go_enter = 1'b1;
            ph_new   = PH_WA_HI;
          end
          PH_WA_HI: begin
            nack_nxt = in_sda_in;
            if (flags_r.stop || (ack_check_r && in_sda_in)) begin
              go_enter = 1'b1;
              ph_new   = PH_SP_A;
            end else begin
              go_finish = 1'b1;
              done_nxt  = 1'b1;
              fin_lvl   = '{scl: 1'b0, sda: 1'b1};
            end
          end
          PH_R_LO: begin
            go_enter = 1'b1;
            ph_new   = PH_R_HI;
          end
          PH_R_HI: begin
            go_enter    = 1'b1;
            shift_nxt   = {shift_r[6:0], in_sda_in};
            bit_idx_nxt = bit_idx_r + 4'd1;
            if (bit_idx_nxt >= 4'd8) begin
              rdata_nxt = shift_nxt;
              ph_new    = PH_RA_LO;
            end else begin
              ph_new = PH_R_LO;
            end
          end
          PH_RA_LO: begin
            go_enter = 1'b1;
            ph_new   = PH_RA_HI;
          end
          PH_RA_HI: begin
            if (flags_r.stop) begin
              go_enter = 1'b1;
              ph_new   = PH_SP_A;
            end else begin
              go_finish = 1'b1;
              done_nxt  = 1'b1;
              fin_lvl   = '{scl: 1'b0, sda: 1'b1};
            end
          end
          PH_SP_A: begin
            go_enter = 1'b1;
            ph_new   = PH_SP_B;
          end
          PH_SP_B: begin
            go_finish = 1'b1;
            done_nxt  = 1'b1;
            fin_lvl   = '{scl: 1'b1, sda: 1'b1};
          end
          default: begin
            go_finish = 1'b1;
            fin_lvl   = '{scl: 1'b1, sda: 1'b1};
          end
        endcase
      end
    end

    // Drive bus levels of the phase entered, or rest the bus
    new_lvl = phase_levels(ph_new, shift_nxt[7], flags_nxt.ack);
    if (go_enter) begin
      phase_nxt = ph_new;
      tick_nxt  = '0;
      scl_nxt   = new_lvl.scl;
      sda_nxt   = new_lvl.sda;
    end else if (go_finish) begin
      phase_nxt = PH_IDLE;
      tick_nxt  = '0;
      scl_nxt   = fin_lvl.scl;
      sda_nxt   = fin_lvl.sda;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
      ack_check_r   <= ACK_CHECK_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_PHASE_TICKS: phase_ticks_r <= cfg_wdata;
        CFG_ACK_CHECK:   ack_check_r   <= cfg_wdata[0];
        default:         ;
      endcase
    end
  end

  // Advance sequencer state and load the result on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_idx_r <= 4'd0;
      shift_r   <= 8'h00;
      tick_r    <= '0;
      flags_r   <= '0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      nack_r    <= 1'b0;
      rdata_r   <= 8'h00;
      done_r    <= 1'b0;
      busy_r    <= 1'b0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      tick_r    <= tick_nxt;
      flags_r   <= flags_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      nack_r    <= nack_nxt;
      rdata_r   <= rdata_nxt;
      done_r    <= done_nxt;
      busy_r    <= (phase_nxt != PH_IDLE);
    end
  end

  // Track result register occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_scl_out     = scl_r;
  assign out_sda_release = sda_r;
  assign out_busy_res    = busy_r;
  assign out_done_res    = done_r;
  assign out_read_byte   = rdata_r;
  assign out_got_nack    = nack_r;

endmodule
`default_nettype wire

@@ rtl/i2cm_checker.sv @@
// Port-level checks for the I2C master byte engine, bound to the top level.
`default_nettype none
module i2cm_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_sda_release,
  input wire logic out_busy_res,
  input wire logic out_done_res
);

  // Remember busy of the last word taken
  logic last_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_busy_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      last_busy_r <= out_busy_res;
    end
  end

  // Done pulse only closes a command: engine is idle on that word
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> !out_busy_res)
    else $error("done shown while still busy");

  // Done follows a busy word
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> last_busy_r)
    else $error("done without a preceding busy word");

  // Idle bus always rests with SDA released
  a_idle_sda: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_busy_res) |-> out_sda_release)
    else $error("SDA driven low while idle");

  // Empty result register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_busy_res)
      && $stable(out_done_res) && $stable(out_sda_release)))
    else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_sda_release (out_sda_release),
  .out_busy_res    (out_busy_res),
  .out_done_res    (out_done_res)
);
`default_nettype wire
